// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Clocked, reset-qualified property assertions that report with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property at every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion lbl failed");

// Assert an implication: whenever cond holds, prop must hold too.
`define ASSERT_IMPL(lbl, clk, rst_n, cond, prop) \
  `ASSERT_CLK(lbl, clk, rst_n, (cond) |-> (prop))

`endif

// ----- src/c32f_pkg.sv -----
// Package for the CRC-32 frame append/check core.
// Types, codes and the CRC byte update; no dependencies.
`timescale 1ns / 1ps

package c32f_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [6:0]  HDR_LEN_RESET = 7'd7;
  localparam logic [7:0]  CNT_MAX       = 8'hFF;
  localparam int          MAX_RES       = 5;

  localparam logic        ACT_SEND    = 1'b0;
  localparam logic        ACT_CHECK   = 1'b1;

  localparam logic        KIND_DATA   = 1'b0;
  localparam logic        KIND_STATUS = 1'b1;

  localparam logic [1:0]  STAT_OK     = 2'd0;
  localparam logic [1:0]  STAT_SHORT  = 2'd1;
  localparam logic [1:0]  STAT_BAD    = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       eof;
  } result_t;

  typedef struct packed {
    logic [2:0]                 n;
    result_t [MAX_RES-1:0]      item;
  } burst_t;

  // Reflected CRC-32, one byte, eight unrolled shift/xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/crc32_frame_append_and_check_core.sv -----
// Top level of the CRC-32 frame append/check core.
// Depends on c32f_pkg and c32f_frame.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_action, in_data_byte, in_last, in_with_crc
//  out     | out_valid/out_stall| out_kind, out_out_byte, out_status,
//          |                    | out_end_of_frame
//  cfg     | cfg_valid/cfg_ready| cfg_data (header_length)
//
// One request per cycle when the queue empties. Each accepted request yields 0
// to 5 results, which are loaded into a 5-entry result queue in the same edge
// and drained one per cycle unless out stalls. The next request is taken in
// the cycle the last queued result leaves.
// Reset (rst_n low, synchronous) clears CRC, trailer window, count and queue;
// header_length returns to 7. A stall on out holds the queue head and, while
// any result waits, stalls the request side too.
`timescale 1ns / 1ps

module crc32_frame_append_and_check_core import c32f_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  input  logic       in_with_crc,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_end_of_frame,
  // config write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0]                hdr_len_r;
  result_t [MAX_RES-1:0]     q_r, q_nxt;
  logic [2:0]                q_cnt_r, q_cnt_nxt;
  logic                      pop, accept;
  burst_t                    burst;

  // config register is always writable; writes must only come while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_len_r <= HDR_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hdr_len_r <= cfg_data;
    end
  end

  // Take a new request only when the queue is empty after this cycle:
  // empty now, or its single entry leaves this edge.
  assign out_valid = (q_cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (q_cnt_r > 3'd1) || ((q_cnt_r == 3'd1) && out_stall);
  assign accept    = in_valid && !in_stall;

  c32f_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .action        (in_action),
    .data_byte     (in_data_byte),
    .last          (in_last),
    .with_crc      (in_with_crc),
    .header_length (hdr_len_r),
    .burst         (burst)
  );

  // Result queue: head at entry 0, shifts down on each pop.
  always_comb begin
    q_nxt     = q_r;
    q_cnt_nxt = q_cnt_r;
    if (accept) begin
      q_nxt     = burst.item;
      q_cnt_nxt = burst.n;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      q_cnt_nxt = q_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_kind         = q_r[0].kind;
  assign out_out_byte     = q_r[0].data;
  assign out_status       = q_r[0].status;
  assign out_end_of_frame = q_r[0].eof;

endmodule

// ----- src/c32f_frame.sv -----
// Frame state (CRC, trailer window, byte count) and per-request result burst.
// Depends on c32f_pkg.
`timescale 1ns / 1ps

module c32f_frame import c32f_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       with_crc,
  input  logic [6:0] header_length,
  output burst_t     burst
);

  logic [31:0]     crc_r, crc_nxt;
  logic [3:0][7:0] win_r, win_nxt;   // index 3 newest
  logic [7:0]      cnt_r, cnt_nxt;

  logic [7:0]      cnt_inc;
  logic [3:0][7:0] win_sh;
  logic [31:0]     crc_send, crc_chk, fin_send, fin_chk;
  logic            is_short, crc_bad, enough;
  logic [2:0]      held, src;
  logic [1:0]      stat;
  result_t         st_item;

  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;
  assign win_sh   = {data_byte, win_r[3], win_r[2], win_r[1]};
  assign crc_send = crc_byte(crc_r, data_byte);
  assign crc_chk  = crc_byte(crc_r, win_sh[0]);
  assign fin_send = crc_send ^ CRC_ALL_ONES;
  assign fin_chk  = crc_r ^ CRC_ALL_ONES;
  assign enough   = (cnt_inc >= 8'd4);
  assign is_short = (cnt_inc <= ({1'b0, header_length} + 8'd4));
  // oldest trailer byte against the most significant CRC byte
  assign crc_bad  = ({win_sh[0], win_sh[1], win_sh[2], win_sh[3]} != fin_chk);
  assign held     = enough ? 3'd4 : cnt_inc[2:0];

  always_comb begin
    if (is_short) begin
      stat = STAT_SHORT;
    end else if (with_crc && crc_bad) begin
      stat = STAT_BAD;
    end else begin
      stat = STAT_OK;
    end
  end

  assign st_item = '{kind: KIND_STATUS, data: 8'd0, status: stat, eof: 1'b1};

  always_comb begin
    burst = '0;
    src   = '0;
    if (action == ACT_SEND) begin
      burst.item[0] = '{kind: KIND_DATA, data: data_byte, status: STAT_OK, eof: 1'b0};
      burst.item[1] = '{kind: KIND_DATA, data: fin_send[31:24], status: STAT_OK, eof: 1'b0};
      burst.item[2] = '{kind: KIND_DATA, data: fin_send[23:16], status: STAT_OK, eof: 1'b0};
      burst.item[3] = '{kind: KIND_DATA, data: fin_send[15:8], status: STAT_OK, eof: 1'b0};
      burst.item[4] = '{kind: KIND_DATA, data: fin_send[7:0], status: STAT_OK, eof: 1'b1};
      burst.n       = last ? 3'd5 : 3'd1;
    end else if (!last) begin
      burst.item[0] = '{kind: KIND_DATA, data: win_sh[0], status: STAT_OK, eof: 1'b0};
      burst.n       = enough ? 3'd1 : 3'd0;
    end else if (with_crc) begin
      burst.item[0] = st_item;
      burst.n       = 3'd1;
    end else begin
      // release held bytes oldest first, then the status
      for (int k = 0; k < MAX_RES; k++) begin
        src = 3'(k) + (3'd4 - held);
        if (3'(k) < held) begin
          burst.item[k] = '{kind: KIND_DATA, data: win_sh[src[1:0]],
                            status: STAT_OK, eof: 1'b0};
        end else if (3'(k) == held) begin
          burst.item[k] = st_item;
        end
      end
      burst.n = held + 3'd1;
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) begin
        crc_nxt = CRC_ALL_ONES;
        win_nxt = '0;
        cnt_nxt = '0;
      end else if (action == ACT_SEND) begin
        crc_nxt = crc_send;
        cnt_nxt = cnt_inc;
      end else begin
        win_nxt = win_sh;
        cnt_nxt = cnt_inc;
        if (enough) begin
          crc_nxt = crc_chk;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_ALL_ONES;
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/c32f_checker.sv -----
// Port-level checker for the CRC-32 frame core, bound to the top level.
// Depends on c32f_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c32f_checker import c32f_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_out_byte,
  input logic [1:0] out_status,
  input logic       out_end_of_frame
);

  logic st_res;
  logic fields_ok;

  assign st_res    = out_valid && (out_kind == KIND_STATUS);
  // status results carry no byte; data results carry ok status
  assign fields_ok = (out_kind == KIND_STATUS) ? (out_out_byte == 8'd0)
                                               : (out_status == STAT_OK);

  // a status result always closes the frame
  `ASSERT_IMPL(a_status_eof, clk, rst_n, st_res, out_end_of_frame)
  `ASSERT_IMPL(a_field_zero, clk, rst_n, out_valid, fields_ok)
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status <= STAT_BAD)
  // a blocked result also blocks new requests
  `ASSERT_IMPL(a_back_press, clk, rst_n, out_valid && out_stall, in_stall)
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_out_byte))

endmodule

bind crc32_frame_append_and_check_core c32f_checker u_c32f_checker (.*);

// ----- bench/crc32_frame_tb_pkg.sv -----
// Bench-side helper: the reflected CRC-32 byte update, used to predict the
// check values and to build frames that carry a good trailer. Needs c32f_pkg.
`timescale 1ns / 1ps

package crc32_frame_tb_pkg;
  import c32f_pkg::*;

  // Serial LFSR form: one data bit into the feedback per step, lsb first.
  function automatic logic [31:0] crc32_feed_byte(input logic [31:0] acc,
                                                  input logic [7:0]  b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ----- bench/crc32_frame_append_and_check_core_checker.sv -----
// Checker for the CRC-32 frame core: watches the request, result and config
// channels, predicts every result and compares it. Needs c32f_pkg, crc32_frame_tb_pkg.
`timescale 1ns / 1ps

module crc32_frame_append_and_check_core_checker
  import c32f_pkg::*;
  import crc32_frame_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  input  logic       in_with_crc,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_out_byte,
  input  logic [1:0] out_status,
  input  logic       out_end_of_frame,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output int         mismatch_count,
  output int         results_pending
);

  logic [6:0]  hdr_len;
  logic [31:0] crc_acc;
  logic [7:0]  window [4];   // [3] newest
  logic [7:0]  frame_len;    // saturating
  result_t     expected_results [$];

  function automatic result_t data_result(input logic [7:0] b, input logic eof);
    result_t r;
    r.kind   = KIND_DATA;
    r.data   = b;
    r.status = STAT_OK;
    r.eof    = eof;
    return r;
  endfunction

  task automatic clear_frame();
    crc_acc = CRC_ALL_ONES;
    foreach (window[i]) window[i] = 8'd0;
    frame_len = 8'd0;
  endtask

  task automatic predict_results(input logic act, input logic [7:0] b,
                                 input logic last, input logic with_crc);
    logic [31:0] fin;
    int          held;
    result_t     st;
    if (frame_len != CNT_MAX) frame_len++;
    if (act == ACT_SEND) begin
      crc_acc = crc32_feed_byte(crc_acc, b);
      expected_results.push_back(data_result(b, 1'b0));
      if (last) begin
        fin = crc_acc ^ CRC_ALL_ONES;
        expected_results.push_back(data_result(fin[31:24], 1'b0));
        expected_results.push_back(data_result(fin[23:16], 1'b0));
        expected_results.push_back(data_result(fin[15:8], 1'b0));
        expected_results.push_back(data_result(fin[7:0], 1'b1));
        clear_frame();
      end
    end else begin
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = b;
      if (!last) begin
        // oldest byte leaves the window once four are in
        if (frame_len >= 8'd4) begin
          crc_acc = crc32_feed_byte(crc_acc, window[0]);
          expected_results.push_back(data_result(window[0], 1'b0));
        end
      end else begin
        fin       = crc_acc ^ CRC_ALL_ONES;
        st.kind   = KIND_STATUS;
        st.data   = 8'd0;
        st.eof    = 1'b1;
        if (int'(frame_len) <= int'(hdr_len) + 4)
          st.status = STAT_SHORT;
        else if (with_crc && {window[0], window[1], window[2], window[3]} != fin)
          st.status = STAT_BAD;
        else
          st.status = STAT_OK;
        if (!with_crc) begin
          held = (frame_len < 8'd4) ? int'(frame_len) : 4;
          for (int i = 4 - held; i < 4; i++)
            expected_results.push_back(data_result(window[i], 1'b0));
        end
        expected_results.push_back(st);
        clear_frame();
      end
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      hdr_len = HDR_LEN_RESET;
      clear_frame();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d byte %0d status %0d eof %0d",
                 out_kind, out_out_byte, out_status, out_end_of_frame);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_kind", want.kind, out_kind);
          check_field("out_out_byte", want.data, out_out_byte);
          check_field("out_status", want.status, out_status);
          check_field("out_end_of_frame", want.eof, out_end_of_frame);
        end
      end
      if (cfg_valid && cfg_ready) hdr_len = cfg_data;
      if (in_valid && !in_stall)
        predict_results(in_action, in_data_byte, in_last, in_with_crc);
    end
    results_pending <= expected_results.size();
  end

endmodule

// ----- bench/crc32_frame_append_and_check_core_tb.sv -----
// Top of the CRC-32 frame core bench: clock, reset, request stimulus, result
// stall pattern, header_length writes and verdict. Needs the core and its checker.
`timescale 1ns / 1ps

module crc32_frame_append_and_check_core_tb;
  import c32f_pkg::*;
  import crc32_frame_tb_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int PHASE_REQUESTS   = 12;

  // Frame shapes the stimulus builds.
  typedef enum {
    FR_SEND,           // append mode, CRC goes out after the last byte
    FR_CHECK_GOOD,     // check mode, trailer matches the payload
    FR_CHECK_CORRUPT,  // check mode, one bit flipped somewhere
    FR_CHECK_PLAIN,    // check mode, no trailer: held bytes come back out
    FR_MIXED           // action drawn per byte
  } frame_kind_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_action;
  logic [7:0] in_data_byte;
  logic       in_last;
  logic       in_with_crc;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_out_byte;
  logic [1:0] out_status;
  logic       out_end_of_frame;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;
  int         mismatch_count;
  int         results_pending;

  // Idle knobs, flipped per phase so that both busy and gappy stretches occur.
  bit         sender_gaps_on;
  bit         receiver_gaps_on;
  bit         receiver_hold_request;
  int         hdr_now;
  int         cycle_count;

  crc32_frame_append_and_check_core dut (.*);

  crc32_frame_append_and_check_core_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("crc32_frame_append_and_check_core: mismatch");
      $finish;
    end
  end

  // Idle gap draw: always zero when disabled, else half the draws are zero and the rest nonzero.
  function automatic int idle_cycles(input bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // Result side: a fresh stall draw per result, plus one long hold-off on
  // request from the stimulus so the block fills and stalls its input.
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (receiver_hold_request) begin
        receiver_hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = idle_cycles(receiver_gaps_on);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One request. Valid stays up into the next request when the gap drawn
  // after acceptance is zero; otherwise it drops for the gap.
  task automatic send_request(input logic act, input logic [7:0] b,
                              input logic last, input logic with_crc);
    int gap;
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    in_last      <= last;
    in_with_crc  <= with_crc;
    do @(posedge clk); while (in_stall);
    gap = idle_cycles(sender_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input frame_kind_t fk, input int len);
    logic [7:0]  body [$];
    logic [31:0] acc;
    logic        act;
    logic        with_crc;
    logic        last;
    int          flip;
    bit          trailer;
    trailer = (fk == FR_CHECK_GOOD || fk == FR_CHECK_CORRUPT);
    if (trailer && len >= 4) begin
      acc = CRC_ALL_ONES;
      for (int i = 0; i < len - 4; i++) begin
        body.push_back(8'($urandom_range(0, 255)));
        acc = crc32_feed_byte(acc, body[i]);
      end
      acc ^= CRC_ALL_ONES;
      // trailer goes out most significant byte first
      body.push_back(acc[31:24]);
      body.push_back(acc[23:16]);
      body.push_back(acc[15:8]);
      body.push_back(acc[7:0]);
    end else begin
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    end
    if (fk == FR_CHECK_CORRUPT) begin
      flip = $urandom_range(0, len - 1);
      body[flip] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      case (fk)
        FR_SEND:  act = ACT_SEND;
        FR_MIXED: act = 1'($urandom_range(0, 1));
        default:  act = ACT_CHECK;
      endcase
      // with_crc only counts on the last byte; noise elsewhere
      if (last && trailer) with_crc = 1'b1;
      else if (last && fk == FR_CHECK_PLAIN) with_crc = 1'b0;
      else with_crc = 1'($urandom_range(0, 1));
      send_request(act, body[i], last, with_crc);
    end
  endtask

  // Drain everything, let the block go quiet, then write header_length.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_header_length(input logic [6:0] v);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    hdr_now   = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly lengths around the short/not-short boundary, a few well past it.
  function automatic int pick_len(input int hdr);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(1, 6);
    if (r < 9) return hdr + $urandom_range(2, 9);
    return hdr + $urandom_range(10, 24);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)  return FR_CHECK_GOOD;
    if (r < 13) return FR_SEND;
    if (r < 15) return FR_CHECK_CORRUPT;
    if (r < 18) return FR_CHECK_PLAIN;
    return FR_MIXED;
  endfunction

  initial begin
    logic [6:0] phase_hdr [4];
    int         len;
    int         phase_start;
    int         items_sent;
    phase_hdr = '{7'd64, 7'd3, 7'd0, 7'd20};
    phase_hdr[3] = 7'($urandom_range(0, 20));
    items_sent = 0;
    hdr_now = HDR_LEN_RESET;
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;
    receiver_hold_request = 1'b0;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_SEND;
    in_data_byte <= 8'd0;
    in_last      <= 1'b0;
    in_with_crc  <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= 7'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, header_length still at its reset value.
    send_request(ACT_SEND, 8'hFF, 1'b1, 1'b0);   // one-byte frame
    send_request(ACT_SEND, 8'h00, 1'b0, 1'b1);
    send_request(ACT_SEND, 8'hFF, 1'b1, 1'b1);
    send_frame(FR_CHECK_GOOD, 3);    // under four bytes with CRC: none released
    send_frame(FR_CHECK_PLAIN, 6);   // short, held bytes come back
    // No header: a five-byte frame is the shortest that is not short.
    write_header_length(7'd0);
    send_frame(FR_CHECK_GOOD, 5);
    send_frame(FR_CHECK_CORRUPT, 6);
    send_frame(FR_MIXED, 4);

    // Random phases over several header lengths and idle patterns.
    for (int p = 0; p < 4; p++) begin
      write_header_length(phase_hdr[p]);
      sender_gaps_on   = p[0];
      receiver_gaps_on = p[1];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_REQUESTS) begin
        len = pick_len(hdr_now);
        send_frame(pick_kind(), len);
        items_sent += len;
      end
    end

    // Back-pressure: long hold on results while requests keep coming.
    write_header_length(HDR_LEN_RESET);
    sender_gaps_on = 1'b0;
    receiver_gaps_on = 1'b0;
    receiver_hold_request = 1'b1;
    repeat (2) send_frame(FR_SEND, 8);
    send_frame(FR_CHECK_GOOD, 14);

    drain_requests();
    if (mismatch_count == 0)
      $display("crc32_frame_append_and_check_core: match");
    else
      $display("crc32_frame_append_and_check_core: mismatch");
    $finish;
  end

endmodule
